// ===== rtl/mteq_pkg.sv =====
// Shared types, constants and widths for the timer expiry queue.
package mteq_pkg;

    localparam int NUM_TIMERS = 64;
    localparam int ID_W       = $clog2(NUM_TIMERS);
    localparam int LINK_W     = $clog2(NUM_TIMERS + 1);
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(NUM_TIMERS);

    // ms / 10 == (ms * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit ms
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef enum logic [2:0] {
        MODE_ALLOC     = 3'd0,
        MODE_RELEASE   = 3'd1,
        MODE_REL_OWNER = 3'd2,
        MODE_START     = 3'd3,
        MODE_STOP      = 3'd4,
        MODE_TICK      = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_EXPIRY = 2'd2
    } kind_t;

    // Decoded command handed from the front part to the back part
    typedef struct packed {
        logic [2:0]      mode;
        logic            id_ok;
        logic [ID_W-1:0] id;
        logic [7:0]      owner;
        logic [31:0]     ticks;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  timer;
        logic [7:0]  owner;
        logic        ok;
        logic        sw;
        logic [31:0] now;
        logic        last;
    } res_t;

    typedef struct packed {
        logic idle;
        logic head_end;
        logic none_running;
        logic run_orphan;
    } status_t;

endpackage

// ===== rtl/multi_timer_expiry_queue_core.sv =====
// Top level of the timer expiry queue: ports, configuration register, assertions.
//
//  channel  direction  signals                         payload
//  s_       in         s_tvalid s_tready s_tdata s_tuser  command item
//  m_       out        m_tvalid m_tready m_tdata m_tuser m_tlast  result item
//  cfg_     in         cfg_valid cfg_ready cfg_data    switch timer id
//
// Allocate scans the status bits. Start walks the deadline list through the
// deadline and next RAMs; release-owner visits every timer, reading and
// checking its owner, freeing each match and unlinking it first when it
// runs. Tick reads and checks the list head once per expired timer. The
// front passes each item through its capture and multiply stages and its
// queue. Reset empties the list and frees all timers at once; either side
// may stall at any time and the front accepts until its stages and queue fill.
module multi_timer_expiry_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timer_id[5:0], owner_id[13:6], delay[45:14], zero
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_timer[5:0], result_owner[13:6], ok[14],
                                   // switch_request[15], now_ticks[47:16]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    logic              q_valid;
    logic              q_ready;
    mteq_pkg::cmd_t    q_cmd;
    mteq_pkg::res_t    res;
    mteq_pkg::status_t status;
    logic [5:0]        switch_id_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_id_reg <= 6'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            switch_id_reg <= cfg_data;
        end
    end

    mteq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    mteq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .switch_id (switch_id_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .status    (status)
    );

    // Pack the result item
    assign m_tdata = {res.now, res.sw, res.ok, res.owner, res.timer};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

`ifndef SYNTHESIS
    a_run_implies_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        !status.run_orphan)
        else $error("running timer is not allocated");

    a_empty_list_none_running: assert property (@(posedge clk) disable iff (!rst_n)
        (status.idle && status.head_end) |-> status.none_running)
        else $error("empty list while timers run");

    a_list_has_runner: assert property (@(posedge clk) disable iff (!rst_n)
        (status.idle && !status.head_end) |-> !status.none_running)
        else $error("list not empty but no timer runs");

    a_expiry_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == mteq_pkg::KIND_EXPIRY) |-> !m_tdata[14])
        else $error("expiry result carries ok");
`endif

endmodule

// ===== rtl/mteq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mteq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mteq_front.sv =====
// Front part: accepts items, scales the timeout to ticks, queues decoded commands.
module mteq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    output logic                q_valid,
    input  logic                q_ready,
    output mteq_pkg::cmd_t      q_cmd
);

    logic             s1_v_reg;
    logic [2:0]       s1_mode_reg;
    logic [5:0]       s1_id_reg;
    logic [7:0]       s1_owner_reg;
    logic [31:0]      s1_ms_reg;
    logic             s2_v_reg;
    mteq_pkg::cmd_t   s2_cmd_reg;
    logic [63:0]      s2_prod_reg;
    mteq_pkg::cmd_t   q_mem_reg [2];
    logic             q_wp_reg;
    logic             q_rp_reg;
    logic [1:0]       q_cnt_reg;

    logic             q_full;
    logic             s2_adv;
    logic             s1_adv;
    logic             q_pop;
    mteq_pkg::cmd_t   q_in;

    // Stage handshakes
    assign q_full   = (q_cnt_reg == 2'd2);
    assign s2_adv   = s2_v_reg && !q_full;
    assign s1_adv   = s1_v_reg && (!s2_v_reg || s2_adv);
    assign s_tready = !s1_v_reg || s1_adv;
    assign q_pop    = q_valid && q_ready;
    assign q_valid  = (q_cnt_reg != 2'd0);
    assign q_cmd    = q_mem_reg[q_rp_reg];

    // Take the quotient from the registered product
    always_comb
    begin
        q_in       = s2_cmd_reg;
        q_in.ticks = 32'(s2_prod_reg >> mteq_pkg::DIV10_SHIFT);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_v_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_v_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_v_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                q_wp_reg <= ~q_wp_reg;
            end
            if (q_pop)
            begin
                q_rp_reg <= ~q_rp_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, s2_adv} - {1'b0, q_pop};
        end
    end

    // Payload: capture, classify and multiply, then enqueue
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_mode_reg  <= s_tuser;
            s1_id_reg    <= s_tdata[5:0];
            s1_owner_reg <= s_tdata[13:6];
            s1_ms_reg    <= s_tdata[45:14];
        end
        if (s1_adv)
        begin
            s2_cmd_reg.mode  <= s1_mode_reg;
            s2_cmd_reg.id_ok <= (int'(s1_id_reg) < mteq_pkg::NUM_TIMERS);
            s2_cmd_reg.id    <= s1_id_reg[mteq_pkg::ID_W-1:0];
            s2_cmd_reg.owner <= s1_owner_reg;
            s2_cmd_reg.ticks <= 32'd0;
            s2_prod_reg      <= 64'(s1_ms_reg) * 64'(mteq_pkg::DIV10_MAGIC);
        end
        if (s2_adv)
        begin
            q_mem_reg[q_wp_reg] <= q_in;
        end
    end

endmodule

// ===== rtl/mteq_back.sv =====
// Back part: timer table, deadline-ordered linked list and result sequencing.
module mteq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  mteq_pkg::cmd_t       q_cmd,
    input  logic [5:0]           switch_id,
    output logic                 res_valid,
    input  logic                 res_ready,
    output mteq_pkg::res_t       res,
    output mteq_pkg::status_t    status
);

    localparam int N  = mteq_pkg::NUM_TIMERS;
    localparam int IW = mteq_pkg::ID_W;
    localparam int LW = mteq_pkg::LINK_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC, S_ROWN_RD, S_ROWN_CHK, S_UL_RD, S_UL_WR, S_REL_FIN,
        S_START_SET, S_WALK_DL, S_WALK_NX, S_LINK1, S_LINK2, S_TICK_RD,
        S_TICK_CHK, S_TICK_END, S_ACK
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    mteq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [LW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    uid_reg, uid_next;
    logic [LW-1:0]    head_reg, head_next;
    logic [31:0]      tick_reg, tick_next;
    logic [N-1:0]     busy_reg, busy_next;
    logic [N-1:0]     run_reg, run_next;
    logic [31:0]      dl_reg, dl_next;
    logic [LW-1:0]    lp_reg, lp_next;
    logic [LW-1:0]    lnx_reg, lnx_next;
    logic             ok_reg, ok_next;
    logic             pend_v_reg, pend_v_next;
    mteq_pkg::res_t   pend_reg, pend_next;
    logic             out_v_reg, out_v_next;
    mteq_pkg::res_t   out_reg, out_next;

    // RAM ports
    logic             own_we, own_re, dl_we, dl_re, nx_we, nx_re, pv_we, pv_re;
    logic [IW-1:0]    own_wa, own_ra, dl_wa, dl_ra, nx_wa, nx_ra, pv_wa, pv_ra;
    logic [7:0]       own_wd, own_rd;
    logic [31:0]      dl_wd, dl_rd;
    logic [LW-1:0]    nx_wd, nx_rd, pv_wd, pv_rd;

    logic             can_push;

    mteq_ram #(.WIDTH(8), .DEPTH(N)) u_owner_ram (
        .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
        .re(own_re), .raddr(own_ra), .rdata(own_rd)
    );
    mteq_ram #(.WIDTH(32), .DEPTH(N)) u_deadline_ram (
        .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
        .re(dl_re), .raddr(dl_ra), .rdata(dl_rd)
    );
    mteq_ram #(.WIDTH(LW), .DEPTH(N)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
    );
    mteq_ram #(.WIDTH(LW), .DEPTH(N)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
    );

    assign can_push  = !out_v_reg || res_ready;
    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    assign status.idle         = (state_reg == S_IDLE);
    assign status.head_end     = (head_reg == mteq_pkg::END_MARK);
    assign status.none_running = (run_reg == '0);
    assign status.run_orphan   = ((run_reg & ~busy_reg) != '0);

    // Sequencer
    always_comb
    begin
        logic           push;
        mteq_pkg::res_t pres;
        logic [IW-1:0]  hid;
        logic [IW-1:0]  iid;

        push        = 1'b0;
        pres        = '0;
        hid         = head_reg[IW-1:0];
        iid         = idx_reg[IW-1:0];
        state_next  = state_reg;
        ret_next    = ret_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        uid_next    = uid_reg;
        head_next   = head_reg;
        tick_next   = tick_reg;
        busy_next   = busy_reg;
        run_next    = run_reg;
        dl_next     = dl_reg;
        lp_next     = lp_reg;
        lnx_next    = lnx_reg;
        ok_next     = ok_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        own_we = 1'b0; own_re = 1'b0; own_wa = '0; own_ra = '0; own_wd = '0;
        dl_we  = 1'b0; dl_re  = 1'b0; dl_wa  = '0; dl_ra  = '0; dl_wd  = '0;
        nx_we  = 1'b0; nx_re  = 1'b0; nx_wa  = '0; nx_ra  = '0; nx_wd  = '0;
        pv_we  = 1'b0; pv_re  = 1'b0; pv_wa  = '0; pv_ra  = '0; pv_wd  = '0;

        case (state_reg)
            // Take the next command and dispatch on its mode
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    uid_next = q_cmd.id;
                    idx_next = '0;
                    ok_next  = 1'b0;
                    case (mteq_pkg::mode_t'(q_cmd.mode))
                        mteq_pkg::MODE_ALLOC:
                        begin
                            state_next = S_ALLOC;
                        end
                        mteq_pkg::MODE_RELEASE:
                        begin
                            ret_next = S_REL_FIN;
                            if (q_cmd.id_ok && busy_reg[q_cmd.id])
                            begin
                                state_next = run_reg[q_cmd.id] ? S_UL_RD : S_REL_FIN;
                            end
                            else
                            begin
                                state_next = S_ACK;
                            end
                        end
                        mteq_pkg::MODE_REL_OWNER:
                        begin
                            state_next = S_ROWN_RD;
                        end
                        mteq_pkg::MODE_START:
                        begin
                            ret_next = S_START_SET;
                            if (q_cmd.id_ok && busy_reg[q_cmd.id])
                            begin
                                state_next = run_reg[q_cmd.id] ? S_UL_RD : S_START_SET;
                            end
                            else
                            begin
                                state_next = S_ACK;
                            end
                        end
                        mteq_pkg::MODE_STOP:
                        begin
                            ret_next = S_ACK;
                            if (q_cmd.id_ok && run_reg[q_cmd.id])
                            begin
                                ok_next    = 1'b1;
                                state_next = S_UL_RD;
                            end
                            else
                            begin
                                state_next = S_ACK;
                            end
                        end
                        mteq_pkg::MODE_TICK:
                        begin
                            tick_next   = tick_reg + 32'd1;
                            pend_v_next = 1'b0;
                            state_next  = S_TICK_RD;
                        end
                        default:
                        begin
                            state_next = S_ACK;
                        end
                    endcase
                end
            end

            // Scan for the lowest free timer
            S_ALLOC:
            begin
                if (idx_reg == mteq_pkg::END_MARK)
                begin
                    pres.kind = mteq_pkg::KIND_ALLOC;
                    pres.last = 1'b1;
                    if (can_push)
                    begin
                        push       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!busy_reg[iid])
                begin
                    pres.kind  = mteq_pkg::KIND_ALLOC;
                    pres.timer = 6'(iid);
                    pres.ok    = 1'b1;
                    pres.last  = 1'b1;
                    if (can_push)
                    begin
                        push            = 1'b1;
                        busy_next[iid]  = 1'b1;
                        own_we          = 1'b1;
                        own_wa          = iid;
                        own_wd          = cmd_reg.owner;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Release-owner: read each owner, free the matches
            S_ROWN_RD:
            begin
                if (idx_reg == mteq_pkg::END_MARK)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    own_re     = 1'b1;
                    own_ra     = iid;
                    state_next = S_ROWN_CHK;
                end
            end

            S_ROWN_CHK:
            begin
                idx_next = idx_reg + 1'b1;
                if (busy_reg[iid] && own_rd == cmd_reg.owner)
                begin
                    uid_next   = iid;
                    ret_next   = S_REL_FIN;
                    state_next = run_reg[iid] ? S_UL_RD : S_REL_FIN;
                end
                else
                begin
                    state_next = S_ROWN_RD;
                end
            end

            // Unlink: fetch both neighbors, then splice around the timer
            S_UL_RD:
            begin
                nx_re      = 1'b1;
                nx_ra      = uid_reg;
                pv_re      = 1'b1;
                pv_ra      = uid_reg;
                state_next = S_UL_WR;
            end

            S_UL_WR:
            begin
                if (head_reg == LW'(uid_reg))
                begin
                    head_next = nx_rd;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = pv_rd[IW-1:0];
                    nx_wd = nx_rd;
                    if (nx_rd != mteq_pkg::END_MARK)
                    begin
                        pv_we = 1'b1;
                        pv_wa = nx_rd[IW-1:0];
                        pv_wd = pv_rd;
                    end
                end
                run_next[uid_reg] = 1'b0;
                state_next        = ret_reg;
            end

            S_REL_FIN:
            begin
                busy_next[uid_reg] = 1'b0;
                run_next[uid_reg]  = 1'b0;
                if (mteq_pkg::mode_t'(cmd_reg.mode) == mteq_pkg::MODE_REL_OWNER)
                begin
                    state_next = S_ROWN_RD;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end

            // Start: store the deadline, then walk for the insert point
            S_START_SET:
            begin
                dl_next           = tick_reg + cmd_reg.ticks;
                dl_we             = 1'b1;
                dl_wa             = uid_reg;
                dl_wd             = tick_reg + cmd_reg.ticks;
                run_next[uid_reg] = 1'b1;
                lp_next           = mteq_pkg::END_MARK;
                lnx_next          = head_reg;
                if (head_reg == mteq_pkg::END_MARK)
                begin
                    state_next = S_LINK1;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = hid;
                    state_next = S_WALK_DL;
                end
            end

            S_WALK_DL:
            begin
                if (dl_reg <= dl_rd)
                begin
                    state_next = S_LINK1;
                end
                else
                begin
                    lp_next    = lnx_reg;
                    nx_re      = 1'b1;
                    nx_ra      = lnx_reg[IW-1:0];
                    state_next = S_WALK_NX;
                end
            end

            S_WALK_NX:
            begin
                lnx_next = nx_rd;
                if (nx_rd == mteq_pkg::END_MARK)
                begin
                    state_next = S_LINK1;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = nx_rd[IW-1:0];
                    state_next = S_WALK_DL;
                end
            end

            // Link the timer between lp and lnx
            S_LINK1:
            begin
                if (lp_reg == mteq_pkg::END_MARK)
                begin
                    head_next = LW'(uid_reg);
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = lp_reg[IW-1:0];
                    nx_wd = LW'(uid_reg);
                end
                pv_we      = 1'b1;
                pv_wa      = uid_reg;
                pv_wd      = lp_reg;
                state_next = S_LINK2;
            end

            S_LINK2:
            begin
                nx_we = 1'b1;
                nx_wa = uid_reg;
                nx_wd = lnx_reg;
                if (lnx_reg != mteq_pkg::END_MARK)
                begin
                    pv_we = 1'b1;
                    pv_wa = lnx_reg[IW-1:0];
                    pv_wd = LW'(uid_reg);
                end
                state_next = S_ACK;
            end

            // Tick: pop expired timers off the head, one behind as pending
            S_TICK_RD:
            begin
                if (head_reg == mteq_pkg::END_MARK)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = hid;
                    own_re     = 1'b1;
                    own_ra     = hid;
                    nx_re      = 1'b1;
                    nx_ra      = hid;
                    state_next = S_TICK_CHK;
                end
            end

            S_TICK_CHK:
            begin
                if (dl_rd <= tick_reg)
                begin
                    pres = pend_reg;
                    if (!pend_v_reg || can_push)
                    begin
                        push            = pend_v_reg;
                        pend_v_next     = 1'b1;
                        pend_next       = '0;
                        pend_next.kind  = mteq_pkg::KIND_EXPIRY;
                        pend_next.timer = 6'(hid);
                        pend_next.owner = own_rd;
                        pend_next.sw    = (6'(hid) == switch_id);
                        run_next[hid]   = 1'b0;
                        head_next       = nx_rd;
                        state_next      = S_TICK_RD;
                    end
                end
                else
                begin
                    state_next = S_TICK_END;
                end
            end

            S_TICK_END:
            begin
                if (pend_v_reg)
                begin
                    pres      = pend_reg;
                    pres.last = 1'b1;
                end
                else
                begin
                    pres.kind = mteq_pkg::KIND_ACK;
                    pres.last = 1'b1;
                end
                if (can_push)
                begin
                    push        = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            S_ACK:
            begin
                pres.kind = mteq_pkg::KIND_ACK;
                pres.ok   = ok_reg;
                pres.last = 1'b1;
                if (can_push)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register: drain on ready, load on push
        pres.now   = tick_next;
        out_v_next = out_v_reg && !res_ready;
        out_next   = out_reg;
        if (push)
        begin
            out_v_next = 1'b1;
            out_next   = pres;
        end
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_ACK;
            head_reg   <= mteq_pkg::END_MARK;
            tick_reg   <= 32'd0;
            busy_reg   <= '0;
            run_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            head_reg   <= head_next;
            tick_reg   <= tick_next;
            busy_reg   <= busy_next;
            run_reg    <= run_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        uid_reg  <= uid_next;
        dl_reg   <= dl_next;
        lp_reg   <= lp_next;
        lnx_reg  <= lnx_next;
        ok_reg   <= ok_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the timer expiry queue core.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    multi_timer_expiry_queue_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [1:0]  tmr_state [mteq_pkg::NUM_TIMERS];
    logic [7:0]  tmr_owner [mteq_pkg::NUM_TIMERS];
    logic [31:0] tmr_due   [mteq_pkg::NUM_TIMERS];
    logic [6:0]  tmr_next  [mteq_pkg::NUM_TIMERS];
    logic [6:0]  due_head;
    logic [31:0] ticks_now;
    logic [5:0]  switch_id;

    mteq_pkg::res_t pending_results[$];
    int   fail_count;
    int   result_count;
    int   expiry_count;
    int   item_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void push_result(mteq_pkg::kind_t k, logic [5:0] t, logic [7:0] o,
                                        logic ok, logic sw, logic lst);
        mteq_pkg::res_t r;
        r.kind = k;
        r.timer = t;
        r.owner = o;
        r.ok = ok;
        r.sw = sw;
        r.now = ticks_now;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void unlink_due(int id);
        int prev;
        int n;
        if (due_head == id)
        begin
            due_head = tmr_next[id];
            return;
        end
        prev = due_head;
        for (n = 0; n < mteq_pkg::NUM_TIMERS && prev < mteq_pkg::NUM_TIMERS; n++)
        begin
            if (tmr_next[prev] == id)
            begin
                tmr_next[prev] = tmr_next[id];
                return;
            end
            prev = tmr_next[prev];
        end
    endfunction

    function automatic void insert_due(int id);
        int prev;
        int nx;
        int n;
        if (due_head >= mteq_pkg::NUM_TIMERS || tmr_due[id] <= tmr_due[due_head])
        begin
            tmr_next[id] = due_head;
            due_head = 7'(id);
            return;
        end
        prev = due_head;
        for (n = 0; n < mteq_pkg::NUM_TIMERS; n++)
        begin
            nx = tmr_next[prev];
            if (nx >= mteq_pkg::NUM_TIMERS || tmr_due[id] <= tmr_due[nx])
            begin
                tmr_next[prev] = 7'(id);
                tmr_next[id] = 7'(nx);
                return;
            end
            prev = nx;
        end
    endfunction

    function automatic void halt_timer(int id);
        if (tmr_state[id] == ST_RUN)
        begin
            unlink_due(id);
            tmr_state[id] = ST_ALLOC;
        end
    endfunction

    // Compute the results of one command item and advance the predictor
    function automatic void predict_timer_cmd(logic [2:0] mode, logic [5:0] id,
                                              logic [7:0] own, logic [31:0] ms);
        logic ok;
        int n;
        int i;
        ok = 1'b0;
        case (mode)
            mteq_pkg::MODE_ALLOC:
            begin
                for (i = 0; i < mteq_pkg::NUM_TIMERS; i++)
                begin
                    if (tmr_state[i] == ST_FREE)
                    begin
                        tmr_state[i] = ST_ALLOC;
                        tmr_owner[i] = own;
                        push_result(mteq_pkg::KIND_ALLOC, 6'(i), 8'd0, 1'b1, 1'b0, 1'b1);
                        return;
                    end
                end
                push_result(mteq_pkg::KIND_ALLOC, 6'd0, 8'd0, 1'b0, 1'b0, 1'b1);
                return;
            end
            mteq_pkg::MODE_RELEASE:
            begin
                if (tmr_state[id] != ST_FREE)
                begin
                    halt_timer(id);
                    tmr_state[id] = ST_FREE;
                end
            end
            mteq_pkg::MODE_REL_OWNER:
            begin
                for (i = 0; i < mteq_pkg::NUM_TIMERS; i++)
                begin
                    if (tmr_state[i] != ST_FREE && tmr_owner[i] == own)
                    begin
                        halt_timer(i);
                        tmr_state[i] = ST_FREE;
                    end
                end
            end
            mteq_pkg::MODE_START:
            begin
                if (tmr_state[id] != ST_FREE)
                begin
                    halt_timer(id);
                    tmr_due[id] = ticks_now + ms / 32'd10;
                    tmr_state[id] = ST_RUN;
                    insert_due(id);
                end
            end
            mteq_pkg::MODE_STOP:
            begin
                if (tmr_state[id] == ST_RUN)
                begin
                    halt_timer(id);
                    ok = 1'b1;
                end
            end
            mteq_pkg::MODE_TICK:
            begin
                ticks_now = ticks_now + 32'd1;
                n = 0;
                while (n < mteq_pkg::NUM_TIMERS && due_head < mteq_pkg::NUM_TIMERS
                       && tmr_due[due_head] <= ticks_now)
                begin
                    i = due_head;
                    tmr_state[i] = ST_ALLOC;
                    due_head = tmr_next[i];
                    push_result(mteq_pkg::KIND_EXPIRY, 6'(i), tmr_owner[i], 1'b0,
                                6'(i) == switch_id, 1'b0);
                    n++;
                end
                if (n > 0)
                begin
                    pending_results[$].last = 1'b1;
                    return;
                end
            end
            default:
            begin
            end
        endcase
        push_result(mteq_pkg::KIND_ACK, 6'd0, 8'd0, ok, 1'b0, 1'b1);
    endfunction

    // Send one command item, with random idle cycles before it
    task automatic send_cmd(logic [2:0] mode, logic [5:0] id, logic [7:0] own,
                            logic [31:0] ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, ms, own, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_timer_cmd(mode, id, own, ms);
        item_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // keep idle after the last expected result has been taken
        repeat (300) @(posedge clk);
    endtask

    task automatic write_switch_id(logic [5:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        switch_id = v;
    endtask

    // Receiver stall pattern
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mteq_pkg::res_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: tuser=%0d tdata=%h", m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                result_count++;
                if (e.kind == mteq_pkg::KIND_EXPIRY)
                    expiry_count++;
                if (m_tuser != e.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata[5:0] != e.timer)
                begin
                    $error("result_timer: expected %0d actual %0d", e.timer, m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[13:6] != e.owner)
                begin
                    $error("result_owner: expected %0d actual %0d", e.owner, m_tdata[13:6]);
                    fail_count++;
                end
                if (m_tdata[14] != e.ok)
                begin
                    $error("ok: expected %0d actual %0d", e.ok, m_tdata[14]);
                    fail_count++;
                end
                if (m_tdata[15] != e.sw)
                begin
                    $error("switch_request: expected %0d actual %0d", e.sw, m_tdata[15]);
                    fail_count++;
                end
                if (m_tdata[47:16] != e.now)
                begin
                    $error("now_ticks: expected %0d actual %0d", e.now, m_tdata[47:16]);
                    fail_count++;
                end
                if (m_tlast != e.last)
                begin
                    $error("last: expected %0d actual %0d", e.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Corner cases: empty pool, full pool, ordering, restart, wrap, bad modes
    task automatic test_directed();
        int i;
        send_cmd(mteq_pkg::MODE_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_STOP, 6'd63, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_RELEASE, 6'd5, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_START, 6'd5, 8'd0, 32'd100);
        send_cmd(mteq_pkg::MODE_ALLOC, 6'd0, 8'hFF, 32'd0);
        send_cmd(mteq_pkg::MODE_ALLOC, 6'd0, 8'h00, 32'd0);
        send_cmd(mteq_pkg::MODE_ALLOC, 6'd0, 8'hA5, 32'd0);
        // equal deadlines leave most recently started first; restart moves timer 0
        send_cmd(mteq_pkg::MODE_START, 6'd0, 8'd0, 32'd29);
        send_cmd(mteq_pkg::MODE_START, 6'd1, 8'd0, 32'd20);
        send_cmd(mteq_pkg::MODE_START, 6'd2, 8'd0, 32'd25);
        send_cmd(mteq_pkg::MODE_START, 6'd0, 8'd0, 32'd9);
        send_cmd(mteq_pkg::MODE_STOP, 6'd2, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_STOP, 6'd2, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(3'd6, 6'd1, 8'd1, 32'd1);
        send_cmd(3'd7, 6'd1, 8'd1, 32'd1);
        // largest timeout: the deadline lies far ahead and does not wrap
        send_cmd(mteq_pkg::MODE_START, 6'd1, 8'd0, 32'hFFFF_FFFF);
        send_cmd(mteq_pkg::MODE_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_REL_OWNER, 6'd0, 8'hFF, 32'd0);
        send_cmd(mteq_pkg::MODE_RELEASE, 6'd1, 8'd0, 32'd0);
        for (i = 0; i < mteq_pkg::NUM_TIMERS + 1; i++)
            send_cmd(mteq_pkg::MODE_ALLOC, 6'd0, 8'(i[1:0]), 32'd0);
        send_cmd(mteq_pkg::MODE_REL_OWNER, 6'd0, 8'd1, 32'd0);
        send_cmd(mteq_pkg::MODE_REL_OWNER, 6'd0, 8'd2, 32'd0);
        send_cmd(mteq_pkg::MODE_REL_OWNER, 6'd0, 8'd3, 32'd0);
    endtask

    // Pause until everything is out, then let two started timers expire in one tick
    task automatic test_drain_pause();
        int i;
        wait_drained();
        for (i = 0; i < 6; i++)
            send_cmd(mteq_pkg::MODE_START, 6'(i * 7), 8'd0, 32'd15);
        send_cmd(mteq_pkg::MODE_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(mteq_pkg::MODE_TICK, 6'd0, 8'd0, 32'd0);
    endtask

    // Mostly well-formed sequences on a small owner set, plus noise
    task automatic test_random(int count);
        int i;
        int r;
        logic [31:0] ms;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            ms = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(80);
            if (r < 18)
                send_cmd(mteq_pkg::MODE_ALLOC, 6'd0, 8'($urandom_range(3)), 32'd0);
            else if (r < 40)
                send_cmd(mteq_pkg::MODE_START, 6'($urandom_range(15)), 8'($urandom()), ms);
            else if (r < 70)
                send_cmd(mteq_pkg::MODE_TICK, 6'($urandom()), 8'($urandom()), $urandom());
            else if (r < 78)
                send_cmd(mteq_pkg::MODE_STOP, 6'($urandom_range(15)), 8'd0, 32'd0);
            else if (r < 84)
                send_cmd(mteq_pkg::MODE_RELEASE, 6'($urandom_range(15)), 8'd0, 32'd0);
            else if (r < 88)
                send_cmd(mteq_pkg::MODE_REL_OWNER, 6'd0, 8'($urandom_range(3)), 32'd0);
            else
                send_cmd(3'($urandom()), 6'($urandom()), 8'($urandom()), $urandom());
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < mteq_pkg::NUM_TIMERS; i++)
        begin
            tmr_state[i] = ST_FREE;
            tmr_owner[i] = 8'd0;
            tmr_due[i]   = 32'd0;
            tmr_next[i]  = 7'd0;
        end
        due_head = mteq_pkg::END_MARK;
        ticks_now = 32'd0;
        switch_id = 6'd0;
        fail_count = 0;
        result_count = 0;
        expiry_count = 0;
        item_count = 0;
        send_idle_pct = 27;
        recv_idle_pct = 58;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 48'd0;
        s_tuser = 3'd0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 6'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_switch_id(6'd63);
        test_drain_pause();
        test_random(60);
        write_switch_id(6'd3);
        send_idle_pct = 58;
        recv_idle_pct = 27;
        test_random(60);
        write_switch_id(6'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(45);

        wait_drained();
        $display("Covered %0d command items, %0d results (%0d expiries),",
                 item_count, result_count, expiry_count);
        $display("three switch-timer settings and three idle patterns.");
        if (fail_count == 0)
            $display("** multi_timer_expiry_queue_core: PASSED **");
        else
            $display("** multi_timer_expiry_queue_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** multi_timer_expiry_queue_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mteq_pkg.sv
rtl/mteq_ram.sv
rtl/mteq_front.sv
rtl/mteq_back.sv
rtl/multi_timer_expiry_queue_core.sv
tb/testbench.sv
